/* design/art_pkg.sv */
// Shared types and constants for the aging route table.
// Used by art_cfg_regs, art_entry_unit and aging_route_table; no dependencies.
`default_nettype none

package art_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ROUTE_TIMEOUT = 1'b0;

  localparam logic [15:0] TIMEOUT_RESET = 16'd300;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  localparam logic [2:0] FUNC_LOOKUP = 3'd0;
  localparam logic [2:0] FUNC_LEARN = 3'd1;
  localparam logic [2:0] FUNC_CLEAR = 3'd2;
  localparam logic [2:0] FUNC_TICK = 3'd3;
  localparam logic [2:0] FUNC_MARK = 3'd4;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_DISCOVERING = 2'd1;
  localparam logic [1:0] ST_VALID = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] destination;
    logic [7:0] next_hop;
    logic [7:0] hop_count;
  } req_t;

  typedef struct packed {
    logic found;
    logic [3:0] slot;
    logic [1:0] route_state;
    logic [7:0] route_next_hop;
    logic [7:0] route_hops;
    logic [15:0] route_age;
    logic evicted;
  } resp_t;

  // One RAM word: everything of an entry but its status.
  typedef struct packed {
    logic [7:0] key;
    logic [7:0] via;
    logic [7:0] hops;
    logic [15:0] age;
  } entry_t;

  // Per-entry verdict from the shared compare unit.
  typedef struct packed {
    logic hit;
    logic vacant;
    logic older;
    logic [1:0] tick_status;
    logic [15:0] tick_age;
  } eval_t;

endpackage

`default_nettype wire

/* design/aging_route_table.sv */
// Aging route table top level: sequencer, entry RAM and status flops.
// Instantiates art_cfg_regs and art_entry_unit; depends on art_pkg.
//
// Usage: requests enter on in_valid/in_ready as art_pkg::req_t (lookup, learn,
// clear, tick, mark discovering). Every request yields exactly one result
// transaction on out_valid/out_ready as art_pkg::resp_t.
// Each request walks the whole table through the entry RAM, one entry per
// cycle through its single read port, with one shared compare unit judging
// the entry read in the previous cycle. After the scan a pick step registers
// the chosen slot and a finish step posts the result. in_ready stays low
// from acceptance until the sequencer is back in its idle step, which
// accepts the next request; a new request is not taken before the last one
// is through.
// The result sits in an output register: a new request is taken while it
// waits, and the sequencer holds in its final step only if the previous
// result has not been taken yet.
// Reset clears all entry status flops to invalid at once (no clearing pass)
// and loads route_timeout with 300; route_timeout is written through the APB-style
// port at byte address 0, by the user only while the table is idle (not enforced).
`default_nettype none

module aging_route_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [art_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [art_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [art_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire art_pkg::req_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output art_pkg::resp_t                        out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PICK, S_FINISH} state_t;

  state_t state;
  art_pkg::req_t req;
  logic [CNT_W-1:0] cnt;
  logic pend_valid;
  logic [IDX_W-1:0] pend_idx;
  art_pkg::entry_t rd_entry;
  logic [1:0] rd_status;
  logic [1:0] status [TABLE_ENTRIES];
  art_pkg::entry_t mem [TABLE_ENTRIES];

  logic m_found;
  logic [IDX_W-1:0] m_idx;
  logic f_found;
  logic [IDX_W-1:0] f_idx;
  logic [15:0] best_age;
  logic [IDX_W-1:0] best_idx;

  logic sel_hit;
  logic [IDX_W-1:0] sel_idx;
  logic sel_ev;

  logic pick_hit;
  logic [IDX_W-1:0] pick_idx;
  logic pick_ev;

  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  art_pkg::entry_t wr_data;
  logic finish_go;
  art_pkg::resp_t resp;
  art_pkg::eval_t verdict;
  logic [15:0] route_timeout;

  art_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .route_timeout (route_timeout)
  );

  art_entry_unit u_unit (
    .status        (rd_status),
    .entry         (rd_entry),
    .destination   (req.destination),
    .route_timeout (route_timeout),
    .best_age      (best_age),
    .verdict       (verdict)
  );

  assign in_ready = (state == S_IDLE);
  assign finish_go = (state == S_FINISH) && (!out_valid || out_ready);

  // Choose the slot once the scan is done.
  always_comb begin
    pick_hit = 1'b0;
    pick_idx = m_idx;
    pick_ev = 1'b0;
    case (req.func)
      art_pkg::FUNC_LOOKUP, art_pkg::FUNC_CLEAR: begin
        pick_hit = m_found;
      end
      art_pkg::FUNC_LEARN: begin
        pick_hit = 1'b1;
        if (m_found) begin
          pick_idx = m_idx;
        end else if (f_found) begin
          pick_idx = f_idx;
        end else begin
          pick_idx = best_idx;
          pick_ev = 1'b1;
        end
      end
      art_pkg::FUNC_MARK: begin
        pick_hit = m_found || f_found;
        pick_idx = m_found ? m_idx : f_idx;
      end
      default: begin
        pick_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = cnt[IDX_W-1:0];
    if (state == S_SCAN && cnt != LAST_CNT) begin
      rd_en = 1'b1;
    end else if (state == S_PICK) begin
      rd_en = 1'b1;
      rd_addr = pick_idx;
    end

    wr_en = 1'b0;
    wr_addr = pend_idx;
    wr_data = rd_entry;
    if (state == S_SCAN && pend_valid && req.func == art_pkg::FUNC_TICK &&
        verdict.tick_status != art_pkg::ST_INVALID) begin
      wr_en = 1'b1;
      wr_data.age = verdict.tick_age;
    end else if (finish_go && sel_hit) begin
      wr_addr = sel_idx;
      if (req.func == art_pkg::FUNC_LEARN) begin
        wr_en = 1'b1;
        wr_data = '{key: req.destination, via: req.next_hop, hops: req.hop_count,
                    age: 16'd0};
      end else if (req.func == art_pkg::FUNC_MARK) begin
        wr_en = 1'b1;
        wr_data = '{key: req.destination, via: rd_entry.via, hops: rd_entry.hops,
                    age: 16'd0};
      end
    end
  end

  always_comb begin
    resp = '0;
    if (sel_hit) begin
      resp.found = 1'b1;
      resp.slot = 4'(sel_idx);
      resp.evicted = sel_ev;
      resp.route_next_hop = rd_entry.via;
      resp.route_hops = rd_entry.hops;
      resp.route_age = rd_entry.age;
      resp.route_state = rd_status;
      case (req.func)
        art_pkg::FUNC_LEARN: begin
          resp.route_state = art_pkg::ST_VALID;
          resp.route_next_hop = req.next_hop;
          resp.route_hops = req.hop_count;
          resp.route_age = 16'd0;
        end
        art_pkg::FUNC_MARK: begin
          resp.route_state = art_pkg::ST_DISCOVERING;
          resp.route_age = 16'd0;
        end
        art_pkg::FUNC_CLEAR: begin
          resp.route_state = art_pkg::ST_INVALID;
        end
        default: begin
          resp.route_state = rd_status;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        status[i] <= art_pkg::ST_INVALID;
      end
    end else begin
      if (out_valid && out_ready && !finish_go) begin
        out_valid <= 1'b0;
      end
      if (rd_en) begin
        rd_status <= status[rd_addr];
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            cnt <= '0;
            pend_valid <= 1'b0;
            m_found <= 1'b0;
            m_idx <= '0;
            f_found <= 1'b0;
            f_idx <= '0;
            best_age <= '0;
            best_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_valid <= rd_en;
          pend_idx <= rd_addr;
          if (pend_valid) begin
            if (req.func == art_pkg::FUNC_TICK) begin
              status[pend_idx] <= verdict.tick_status;
            end
            if (verdict.hit && !m_found) begin
              m_found <= 1'b1;
              m_idx <= pend_idx;
            end
            if (verdict.vacant && !f_found) begin
              f_found <= 1'b1;
              f_idx <= pend_idx;
            end
            if (verdict.older) begin
              best_age <= rd_entry.age;
              best_idx <= pend_idx;
            end
          end
          if (cnt == LAST_CNT) begin
            state <= S_PICK;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_PICK: begin
          sel_hit <= pick_hit;
          sel_idx <= pick_idx;
          sel_ev <= pick_ev;
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the previous result is taken
          if (finish_go) begin
            out_valid <= 1'b1;
            out_data <= resp;
            if (sel_hit) begin
              if (req.func == art_pkg::FUNC_LEARN) begin
                status[sel_idx] <= art_pkg::ST_VALID;
              end else if (req.func == art_pkg::FUNC_MARK) begin
                status[sel_idx] <= art_pkg::ST_DISCOVERING;
              end else if (req.func == art_pkg::FUNC_CLEAR) begin
                status[sel_idx] <= art_pkg::ST_INVALID;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.evicted || out_data.found))
    else $error("evicted result without a slot");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.slot == 4'd0 &&
      out_data.route_state == art_pkg::ST_INVALID && out_data.route_age == 16'd0 &&
      out_data.route_next_hop == 8'd0 && out_data.route_hops == 8'd0))
    else $error("miss result carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a request");

  a_new_result: assert property (@(posedge clk) disable iff (rst)
    (finish_go) |=> (out_valid && in_ready))
    else $error("finish step did not post a result");

endmodule

`default_nettype wire

/* design/art_cfg_regs.sv */
// APB-style configuration register block for the aging route table.
// Holds route_timeout; depends on art_pkg.
`default_nettype none

module art_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [art_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [art_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [art_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic      [15:0]                      route_timeout
);

  logic reg_index;

  assign reg_index = paddr[2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_timeout <= art_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_index == art_pkg::REG_ROUTE_TIMEOUT) begin
        route_timeout <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == art_pkg::REG_ROUTE_TIMEOUT) begin
      prdata = {{(art_pkg::CFG_DATA_W - 16){1'b0}}, route_timeout};
    end
  end

endmodule

`default_nettype wire

/* design/art_entry_unit.sv */
// Shared compare and aging unit: judges one table entry per cycle.
// Gives key match, vacancy, eviction age compare and tick update; uses art_pkg.
`default_nettype none

module art_entry_unit (
  input  wire logic [1:0]      status,
  input  wire art_pkg::entry_t entry,
  input  wire logic [7:0]      destination,
  input  wire logic [15:0]     route_timeout,
  input  wire logic [15:0]     best_age,
  output art_pkg::eval_t       verdict
);

  logic live;
  logic [1:0] status_after;

  assign live = (status != art_pkg::ST_INVALID);

  always_comb begin
    status_after = status;
    // expire before aging
    if (status == art_pkg::ST_VALID && entry.age >= route_timeout) begin
      status_after = art_pkg::ST_INVALID;
    end
    verdict.hit = live && (entry.key == destination);
    verdict.vacant = !live;
    verdict.older = live && (entry.age > best_age);
    verdict.tick_status = status_after;
    verdict.tick_age = entry.age;
    if (status_after != art_pkg::ST_INVALID && entry.age != art_pkg::AGE_MAX) begin
      verdict.tick_age = entry.age + 16'd1;
    end
  end

endmodule

`default_nettype wire
